// File: hw/rtl/ddfi_pkg.sv
// Shared types and constants for the decimal digit field insert unit.
// Depends on nothing; every other file of the block imports it.
package ddfi_pkg;

    localparam int DATA_W      = 64;
    localparam int SPAN_W      = 5;
    localparam int NUM_DIGITS  = 20;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int DIGIT_LIMIT = 19;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [BCD_W-1:0]  bcd_t;
    typedef logic [SPAN_W-1:0] span_t;

    // Operations of the shared shift/add unit.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_DABBLE,
        OP_SWAP,
        OP_MERGE,
        OP_HORNER
    } ddfi_op_t;

endpackage

// File: hw/rtl/ddfi_digit_merge.sv
// Decimal digit selection: takes the kept digits of the base operand and
// the low digits of the source operand shifted into the span.
// Depends on ddfi_pkg.
module ddfi_digit_merge (
    input  ddfi_pkg::bcd_t  base_bcd,
    input  ddfi_pkg::bcd_t  src_bcd,
    input  ddfi_pkg::span_t low_idx,
    input  ddfi_pkg::span_t high_idx,
    output ddfi_pkg::bcd_t  merged_bcd
);
    import ddfi_pkg::*;

    bcd_t shifted;

    // Source digit k lands on digit index k + low_idx.
    assign shifted = src_bcd << {low_idx, 2'b00};

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if ((SPAN_W'(i) >= low_idx) && (SPAN_W'(i) <= high_idx))
            begin
                merged_bcd[4*i +: 4] = shifted[4*i +: 4];
            end
            else
            begin
                merged_bcd[4*i +: 4] = base_bcd[4*i +: 4];
            end
        end
    end

endmodule

// File: hw/rtl/ddfi_shift_unit.sv
// Shared shift/add unit: binary to BCD by shift and add-3, digit merge,
// and BCD to binary by multiply-by-ten accumulation.
// Depends on ddfi_pkg and ddfi_digit_merge.
module ddfi_shift_unit (
    input  logic            clk,
    input  ddfi_pkg::ddfi_op_t op,
    input  ddfi_pkg::data_t load_value,
    input  ddfi_pkg::span_t low_idx,
    input  ddfi_pkg::span_t high_idx,
    output ddfi_pkg::data_t acc
);
    import ddfi_pkg::*;

    data_t bin_reg;
    data_t bin_next;
    bcd_t  bcd_reg;
    bcd_t  bcd_next;
    bcd_t  hold_reg;
    bcd_t  hold_next;
    bcd_t  adjusted;
    bcd_t  merged;

    ddfi_digit_merge u_merge (
        .base_bcd   (hold_reg),
        .src_bcd    (bcd_reg),
        .low_idx    (low_idx),
        .high_idx   (high_idx),
        .merged_bcd (merged)
    );

    // Add 3 to every digit of 5 or more before the next doubling.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                adjusted[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adjusted[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        hold_next = hold_reg;
        case (op)
            OP_LOAD:
            begin
                bin_next = load_value;
                bcd_next = '0;
            end
            OP_DABBLE:
            begin
                bcd_next = {adjusted[BCD_W-2:0], bin_reg[DATA_W-1]};
                bin_next = {bin_reg[DATA_W-2:0], 1'b0};
            end
            OP_SWAP:
            begin
                hold_next = bcd_reg;
                bin_next  = load_value;
                bcd_next  = '0;
            end
            OP_MERGE:
            begin
                bcd_next = merged;
                bin_next = '0;
            end
            OP_HORNER:
            begin
                // acc * 10 + top digit, wrapping modulo 2^64.
                bin_next = {bin_reg[DATA_W-4:0], 3'b000} + {bin_reg[DATA_W-2:0], 1'b0}
                         + {{(DATA_W-4){1'b0}}, bcd_reg[BCD_W-1 -: 4]};
                bcd_next = {bcd_reg[BCD_W-5:0], 4'b0000};
            end
            default:
            begin
                bin_next = bin_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        hold_reg <= hold_next;
    end

    assign acc = bin_reg;

endmodule

// File: hw/rtl/decimal_digit_field_insert_unit.sv
// Top level of the decimal digit field insert unit: command handshake,
// sequencer and result register. Depends on ddfi_pkg and ddfi_shift_unit.
//
// A transaction is accepted on a rising edge where start is high and busy is
// low. A valid span converts base_value to BCD, stores that BCD and loads
// new_digits, converts new_digits, does the digit merge, runs multiply-by-ten
// accumulation back to binary and loads the sum into the result register.
// All of it runs through one shared shift/add unit, so no new transaction is
// taken while busy is high. An invalid span (not 1 <= low <= high <= 19)
// returns base_value with span_error set in the cycle right after acceptance.
// Each result is shown for exactly one cycle with done high; the receiver
// cannot stall it, so it must take the result in that cycle. busy falls as
// done rises, so a new transaction may start while the previous result is on
// the ports.
module decimal_digit_field_insert_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ddfi_pkg::data_t base_value,
    input  ddfi_pkg::span_t span_low_digit,
    input  ddfi_pkg::span_t span_high_digit,
    input  ddfi_pkg::data_t new_digits,
    output logic            done,
    output ddfi_pkg::data_t edited_value,
    output logic            span_error
);
    import ddfi_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAB_BASE,
        ST_SWAP,
        ST_DAB_SRC,
        ST_MERGE,
        ST_HORNER,
        ST_FINISH
    } state_t;

    localparam int CNT_W = $clog2(DATA_W);

    state_t     state_reg;
    logic [CNT_W-1:0] cnt_reg;
    data_t      src_reg;
    span_t      low_idx_reg;
    span_t      high_idx_reg;
    logic       done_reg;
    logic       span_error_reg;
    data_t      edited_value_reg;

    logic       accept;
    logic       span_ok;
    ddfi_op_t   op;
    data_t      load_value;
    data_t      acc;

    assign accept  = start && (state_reg == ST_IDLE);
    assign span_ok = (span_low_digit != '0) && (span_high_digit >= span_low_digit)
                  && (span_high_digit <= SPAN_W'(DIGIT_LIMIT));

    // The unit loads base_value on acceptance and new_digits at the swap.
    assign load_value = (state_reg == ST_IDLE) ? base_value : src_reg;

    always_comb
    begin
        case (state_reg)
            ST_IDLE:     op = (accept && span_ok) ? OP_LOAD : OP_HOLD;
            ST_DAB_BASE: op = OP_DABBLE;
            ST_SWAP:     op = OP_SWAP;
            ST_DAB_SRC:  op = OP_DABBLE;
            ST_MERGE:    op = OP_MERGE;
            ST_HORNER:   op = OP_HORNER;
            default:     op = OP_HOLD;
        endcase
    end

    ddfi_shift_unit u_shift (
        .clk        (clk),
        .op         (op),
        .load_value (load_value),
        .low_idx    (low_idx_reg),
        .high_idx   (high_idx_reg),
        .acc        (acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            src_reg          <= '0;
            low_idx_reg      <= '0;
            high_idx_reg     <= '0;
            done_reg         <= 1'b0;
            span_error_reg   <= 1'b0;
            edited_value_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        src_reg      <= new_digits;
                        // Digit indexes count from zero for the units digit.
                        low_idx_reg  <= span_low_digit - SPAN_W'(1);
                        high_idx_reg <= span_high_digit - SPAN_W'(1);
                        cnt_reg      <= '0;
                        if (span_ok)
                        begin
                            state_reg <= ST_DAB_BASE;
                        end
                        else
                        begin
                            edited_value_reg <= base_value;
                            span_error_reg   <= 1'b1;
                            done_reg         <= 1'b1;
                        end
                    end
                end
                ST_DAB_BASE:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DATA_W - 1))
                    begin
                        state_reg <= ST_SWAP;
                    end
                end
                ST_SWAP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DAB_SRC;
                end
                ST_DAB_SRC:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DATA_W - 1))
                    begin
                        state_reg <= ST_MERGE;
                    end
                end
                ST_MERGE:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_HORNER;
                end
                ST_HORNER:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(NUM_DIGITS - 1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    edited_value_reg <= acc;
                    span_error_reg   <= 1'b0;
                    done_reg         <= 1'b1;
                    state_reg        <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign edited_value = edited_value_reg;
    assign span_error   = span_error_reg;

    // A result is only ever presented once the sequencer is free again.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while sequencer busy");

    // A bad span is answered at once with the error flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !span_ok) |=> (done && span_error && !busy))
        else $error("invalid span not answered in the next cycle");

    // A good span starts a conversion and gives no immediate result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && span_ok) |=> (busy && !done && state_reg == ST_DAB_BASE))
        else $error("valid span did not start the conversion");

    // The accumulation phase always ends in the finish step, then a strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> (done && !span_error))
        else $error("finish step without a clean result strobe");

endmodule

// File: tb/sv/decimal_digit_field_insert_unit_tb.sv
// Self-checking testbench for decimal_digit_field_insert_unit.
// Depends on ddfi_pkg and the unit's RTL. It runs a directed table and then
// random transactions, each checked by the predictor or a typed outcome.
`timescale 1ns / 1ps

module decimal_digit_field_insert_unit_tb;

    import ddfi_pkg::*;

    // Largest power of ten that fits in 64 bits, and the room left above it.
    localparam data_t TEN_POW_19   = 64'd10000000000000000000;
    localparam data_t TEN_POW_18   = 64'd1000000000000000000;
    localparam data_t ABOVE_TEN_19 = 64'd8446744073709551616;
    localparam data_t ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int    RANDOM_ITEMS = 1800;

    // One edit as it leaves the unit.
    typedef struct packed {
        data_t value;
        logic  flag;
    } digit_edit_t;

    // One row of directed stimulus. Where "typed" is set, the expected
    // outcome is written into the row; otherwise the predictor supplies it.
    typedef struct packed {
        data_t base;
        span_t lo;
        span_t hi;
        data_t src;
        bit    typed;
        data_t exp_value;
        logic  exp_flag;
    } edit_row_t;

    localparam int NUM_ROWS = 20;

    // Directed rows: tiny and full spans, the top digit alone, the sum that
    // wraps past 2^64, and every way a span can be out of range.
    localparam edit_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{64'd0, 5'd1, 5'd1, 64'd7, 1'b1, 64'd7, 1'b0},
        '{64'd0, 5'd1, 5'd19, 64'd0, 1'b1, 64'd0, 1'b0},
        '{64'd0, 5'd19, 5'd19, 64'd1, 1'b1, TEN_POW_18, 1'b0},
        '{ALL_ONES, 5'd1, 5'd19, 64'd9999999999999999999, 1'b0, 64'd0, 1'b0},
        '{ALL_ONES, 5'd1, 5'd19, ALL_ONES, 1'b0, 64'd0, 1'b0},
        '{ALL_ONES, 5'd19, 5'd19, 64'd0, 1'b0, 64'd0, 1'b0},
        '{ALL_ONES, 5'd1, 5'd1, 64'd0, 1'b0, 64'd0, 1'b0},
        '{64'd12345678901234567890, 5'd5, 5'd8, 64'd4321, 1'b0, 64'd0, 1'b0},
        '{64'd9999999999999999999, 5'd10, 5'd10, 64'd0, 1'b0, 64'd0, 1'b0},
        '{TEN_POW_19, 5'd1, 5'd18, 64'd123, 1'b0, 64'd0, 1'b0},
        '{64'd0, 5'd1, 5'd19, ALL_ONES, 1'b0, 64'd0, 1'b0},
        '{64'hDEAD_BEEF_CAFE_F00D, 5'd3, 5'd17, 64'h0123_4567_89AB_CDEF,
          1'b0, 64'd0, 1'b0},
        '{64'h1234_5678_9ABC_DEF0, 5'd0, 5'd0, 64'd55, 1'b1,
          64'h1234_5678_9ABC_DEF0, 1'b1},
        '{ALL_ONES, 5'd0, 5'd19, 64'd1, 1'b1, ALL_ONES, 1'b1},
        '{64'd777, 5'd5, 5'd4, 64'd1, 1'b1, 64'd777, 1'b1},
        '{64'd4242, 5'd1, 5'd20, 64'd9, 1'b1, 64'd4242, 1'b1},
        '{ALL_ONES, 5'd31, 5'd31, ALL_ONES, 1'b1, ALL_ONES, 1'b1},
        '{64'd0, 5'd20, 5'd20, 64'd3, 1'b1, 64'd0, 1'b1},
        '{64'd31, 5'd0, 5'd31, 64'd8, 1'b1, 64'd31, 1'b1},
        '{ALL_ONES, 5'd1, 5'd31, 64'd0, 1'b1, ALL_ONES, 1'b1}
    };

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    data_t base_value;
    span_t span_low_digit;
    span_t span_high_digit;
    data_t new_digits;
    logic  done;
    data_t edited_value;
    logic  span_error;

    // Edits accepted by the unit whose results have not come back yet,
    // oldest first.
    digit_edit_t expected_edits[$];
    int          error_count = 0;
    bit          idle_enabled = 1'b1;

    decimal_digit_field_insert_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .base_value      (base_value),
        .span_low_digit  (span_low_digit),
        .span_high_digit (span_high_digit),
        .new_digits      (new_digits),
        .done            (done),
        .edited_value    (edited_value),
        .span_error      (span_error)
    );

    // 100 MHz clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Computes what the unit must return for one transaction. The digits of
    // base above the span and below it are kept, the span is filled from the
    // low decimal digits of src, and the sum wraps at 64 bits. A span outside
    // 1 <= lo <= hi <= 19 hands base back with the flag set.
    function automatic digit_edit_t compute_digit_insert(data_t base, span_t lo,
                                                         span_t hi, data_t src);
        data_t       pow_ten [0:DIGIT_LIMIT];
        digit_edit_t res;
        data_t       acc;
        int          k;
        pow_ten[0] = 64'd1;
        for (k = 1; k <= DIGIT_LIMIT; k++)
        begin
            pow_ten[k] = pow_ten[k-1] * 64'd10;
        end
        if (lo < 1 || hi < lo || hi > DIGIT_LIMIT)
        begin
            res.value = base;
            res.flag  = 1'b1;
            return res;
        end
        acc = (base / pow_ten[hi]) * pow_ten[hi];
        acc = acc + base % pow_ten[lo-1];
        for (k = 0; k <= int'(hi) - int'(lo); k++)
        begin
            acc = acc + ((src / pow_ten[k]) % 64'd10) * pow_ten[k + lo - 1];
        end
        res.value = acc;
        res.flag  = 1'b0;
        return res;
    endfunction

    // Presents one transaction and holds it until the unit takes it. The
    // sender sometimes drops start for a while first; now and then the gap is
    // long enough to land anywhere within the unit's conversion, so requests
    // arrive at every point of the sequence.
    // start is only ever lowered or raised once per edge: when there is no
    // gap it simply stays high from one transaction to the next.
    task automatic issue_edit(input edit_row_t row);
        int gap;
        if (idle_enabled && $urandom_range(0, 99) < 23)
        begin
            if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(20, 170);
            else
                gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        base_value      <= row.base;
        span_low_digit  <= row.lo;
        span_high_digit <= row.hi;
        new_digits      <= row.src;
        // The transaction is taken at the first edge where busy is low. The
        // value read here is the one from just before the edge.
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (row.typed)
            expected_edits.push_back('{row.exp_value, row.exp_flag});
        else
            expected_edits.push_back(compute_digit_insert(row.base, row.lo,
                                                          row.hi, row.src));
    endtask

    // Result checker. done marks a single cycle and cannot be held off, so
    // every edge with done high carries one result that must match the
    // oldest outstanding edit.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_edits.size() == 0)
            begin
                $error("unexpected result: edited_value %0d, span_error %0b",
                       edited_value, span_error);
                error_count++;
            end
            else
            begin
                digit_edit_t exp_edit;
                exp_edit = expected_edits.pop_front();
                if (edited_value !== exp_edit.value)
                begin
                    $error("edited_value mismatch: expected %0d, actual %0d",
                           exp_edit.value, edited_value);
                    error_count++;
                end
                if (span_error !== exp_edit.flag)
                begin
                    $error("span_error mismatch: expected %0b, actual %0b",
                           exp_edit.flag, span_error);
                    error_count++;
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random transactions.
    initial
    begin
        edit_row_t row;
        int        n;
        int        wait_cycles;
        int        kind;

        rst_n           = 1'b0;
        start           = 1'b0;
        base_value      = '0;
        span_low_digit  = '0;
        span_high_digit = '0;
        new_digits      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < NUM_ROWS; n++)
        begin
            issue_edit(DIRECTED_ROWS[n]);
        end

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // A long run with the sender never pausing, so transactions
            // also follow each other back to back.
            idle_enabled = !(n >= 800 && n < 1100);
            row.typed     = 1'b0;
            row.exp_value = '0;
            row.exp_flag  = 1'b0;

            // Base values cover the whole 64-bit range, the region below
            // 10^19, the region above it where the sum can wrap, and a few
            // small numbers whose upper digits are zero.
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: row.base = {$urandom, $urandom};
                3, 4:    row.base = {$urandom, $urandom} % TEN_POW_19;
                5, 6:    row.base = TEN_POW_19 + {$urandom, $urandom} % ABOVE_TEN_19;
                7:       row.base = data_t'($urandom_range(0, 99999));
                8:       row.base = ALL_ONES - data_t'($urandom_range(0, 1000));
                default: row.base = {32'd0, $urandom};
            endcase

            if ($urandom_range(0, 1) == 0)
                row.src = {$urandom, $urandom};
            else
                row.src = data_t'($urandom_range(0, 999999));

            // Most spans are legal; a share of them end at the top digit
            // where the wrap can occur. The rest are out of range, drawn
            // from the full 5-bit space so every bit of both fields toggles.
            if ($urandom_range(0, 99) < 80)
            begin
                row.lo = span_t'($urandom_range(1, DIGIT_LIMIT));
                if ($urandom_range(0, 3) == 0)
                    row.hi = span_t'(DIGIT_LIMIT);
                else
                    row.hi = span_t'($urandom_range(row.lo, DIGIT_LIMIT));
            end
            else
            begin
                do
                begin
                    row.lo = span_t'($urandom_range(0, 31));
                    row.hi = span_t'($urandom_range(0, 31));
                end
                while (row.lo >= 1 && row.hi >= row.lo && row.hi <= DIGIT_LIMIT);
            end

            issue_edit(row);
        end
        start <= 1'b0;

        // Let the last results come back, then watch a while longer for any
        // result the unit should not produce.
        wait_cycles = 0;
        while (expected_edits.size() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (expected_edits.size() != 0)
        begin
            $error("%0d results never arrived", expected_edits.size());
            error_count++;
        end
        repeat (200) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #30_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/ddfi_pkg.sv
hw/rtl/ddfi_digit_merge.sv
hw/rtl/ddfi_shift_unit.sv
hw/rtl/decimal_digit_field_insert_unit.sv
tb/sv/decimal_digit_field_insert_unit_tb.sv
